>>> sv/plvsf_pkg.sv
`default_nettype none
package plvsf_pkg;

	localparam int QW = 55;                 // quotient width of the final divide
	localparam int FW = 32;                 // fraction bits of the squared cosine
	localparam int RW = 32;                 // root bits
	localparam logic [30:0] INF_COEF = 31'd2050695827;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef struct packed {
		logic        zero;   // x = y = z = 0
		logic        full;   // point straight below the load
		logic [63:0] s;      // squared distance
	} side_t;

	typedef struct packed {
		logic          valid;
		side_t         side;
		logic [63:0]   rem;
		logic [QW-1:0] quo;
		logic [QW-1:0] num;
	} div_t;

	typedef struct packed {
		logic          valid;
		side_t         side;
		logic [31:0]   c2;
		logic [63:0]   rad;
		logic [35:0]   rem;
		logic [RW-1:0] root;
	} sqr_t;

endpackage
`default_nettype wire

>>> sv/plvsf_pt_if.sv
`default_nettype none
interface plvsf_pt_if;
	logic        valid;
	logic        ready;
	logic [31:0] x_offset;
	logic [31:0] y_offset;
	logic [30:0] depth;

	modport source (output valid, x_offset, y_offset, depth, input ready);
	modport sink (input valid, x_offset, y_offset, depth, output ready);
endinterface
`default_nettype wire

>>> sv/plvsf_res_if.sv
`default_nettype none
interface plvsf_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] influence;
	logic [31:0] vertical_stress;
	logic [1:0]  status;

	modport source (output valid, influence, vertical_stress, status, input ready);
	modport sink (input valid, influence, vertical_stress, status, output ready);
endinterface
`default_nettype wire

>>> sv/point_load_vertical_stress_factor.sv
// Point load vertical stress factor.
// Input channel pt carries one calculation point per word: x_offset and
// y_offset (signed Q16.16) and depth (unsigned Q16.16). Output channel res
// carries influence (Q8.24), vertical_stress (Q16.16) and status for each
// point, in order. cfg_we/cfg_wdata write load_pressure (Q16.16); write it
// only while no point is in flight.
// One point is accepted every cycle unless res stalls. The chain holds the
// squares and their sum, 32 divider cells for the squared cosine, 32 root
// cells, the cube and coefficient stages, 55 divider cells for the final
// quotient, the stress multiply and the result register, each a register apart.
// When res stalls the whole chain holds and pt.ready falls; a point keeps
// being taken while the result register is free or is being emptied.
// Reset clears every valid flag and load_pressure; no point is in flight.
`default_nettype none
module point_load_vertical_stress_factor
	import plvsf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	plvsf_pt_if.sink         pt,
	plvsf_res_if.source      res,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);

	logic        adv;
	logic [31:0] load_pressure_q;

	logic [31:0] ax, ay;
	logic        v_s1;
	logic [63:0] ax2_s1, ay2_s1;
	logic [61:0] z2_s1;
	logic        v_s2;
	logic [63:0] s_s2;
	logic [61:0] z2_s2;
	logic        full_s2;

	div_t fd [0:FW];
	sqr_t sq [0:RW];
	div_t qd [0:QW];

	logic          v_s3;
	side_t         side_s3;
	logic [32:0]   c3_s3;
	logic [63:0]   prod_c3;
	logic          v_s4;
	side_t         side_s4;
	logic [QW-1:0] num_s4;
	logic [63:0]   prod_k;

	logic          v_s5;
	logic          zero_s5;
	logic          isat_s5;
	logic [31:0]   infl_s5;
	logic [54:0]   hi_s5;
	logic [63:0]   lo_s5;

	logic [40:0]   ssum;
	logic          hsat, ssat;
	logic          out_valid_q;
	logic [31:0]   infl_q, stress_q;
	logic [1:0]    status_q;

	assign adv      = !out_valid_q || res.ready;
	assign pt.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pressure_q <= '0;
		end else if (cfg_we) begin
			load_pressure_q <= cfg_wdata;
		end
	end

	assign ax = pt.x_offset[31] ? 32'(-pt.x_offset) : pt.x_offset;
	assign ay = pt.y_offset[31] ? 32'(-pt.y_offset) : pt.y_offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pt.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax2_s1  <= 64'(ax) * 64'(ax);
			ay2_s1  <= 64'(ay) * 64'(ay);
			z2_s1   <= 62'(62'(pt.depth) * 62'(pt.depth));
			s_s2    <= ax2_s1 + ay2_s1 + 64'(z2_s1);
			z2_s2   <= z2_s1;
			full_s2 <= 64'(z2_s1) >= ax2_s1 + ay2_s1 + 64'(z2_s1);
		end
	end

	// squared cosine: z^2 / s as a Q0.32 fraction
	always_comb begin
		fd[0].valid     = v_s2;
		fd[0].side.zero = s_s2 == 64'd0;
		fd[0].side.full = full_s2;
		fd[0].side.s    = s_s2;
		fd[0].rem       = full_s2 ? 64'd0 : 64'(z2_s2);
		fd[0].quo       = '0;
		fd[0].num       = '0;
	end

	for (genvar i = 0; i < FW; i++) begin : g_frac
		plvsf_div_cell u_cell (.clk(clk), .arst_n(arst_n), .en(adv), .d(fd[i]), .q(fd[i+1]));
	end

	always_comb begin
		sq[0].valid = fd[FW].valid;
		sq[0].side  = fd[FW].side;
		sq[0].c2    = fd[FW].quo[FW-1:0];
		sq[0].rad   = {fd[FW].quo[FW-1:0], 32'd0};
		sq[0].rem   = '0;
		sq[0].root  = '0;
	end

	for (genvar i = 0; i < RW; i++) begin : g_root
		plvsf_sqrt_cell u_cell (.clk(clk), .arst_n(arst_n), .en(adv), .d(sq[i]), .q(sq[i+1]));
	end

	assign prod_c3 = 64'(sq[RW].c2) * 64'(sq[RW].root);
	assign prod_k  = 64'(INF_COEF) * 64'(c3_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s3 <= sq[RW].valid;
			v_s4 <= v_s3;
			v_s5 <= qd[QW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= sq[RW].side;
			c3_s3   <= sq[RW].side.full ? 33'h1_0000_0000 : {1'b0, prod_c3[63:32]};
			side_s4 <= side_s3;
			num_s4  <= prod_k[QW+7:8];
		end
	end

	// influence: coefficient times cosine cubed, over s
	always_comb begin
		qd[0].valid = v_s4;
		qd[0].side  = side_s4;
		qd[0].rem   = '0;
		qd[0].quo   = '0;
		qd[0].num   = num_s4;
	end

	for (genvar i = 0; i < QW; i++) begin : g_quot
		plvsf_div_cell u_cell (.clk(clk), .arst_n(arst_n), .en(adv), .d(qd[i]), .q(qd[i+1]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s5 <= qd[QW].side.zero;
			isat_s5 <= |qd[QW].quo[QW-1:32];
			infl_s5 <= |qd[QW].quo[QW-1:32] ? 32'hFFFF_FFFF : qd[QW].quo[31:0];
			hi_s5   <= 55'(64'(qd[QW].quo[QW-1:32]) * 64'(load_pressure_q));
			lo_s5   <= 64'(qd[QW].quo[31:0]) * 64'(load_pressure_q);
		end
	end

	assign hsat = |hi_s5[54:24];
	assign ssum = {9'd0, hi_s5[23:0], 8'd0} + {1'b0, lo_s5[63:24]};
	assign ssat = hsat || (|ssum[40:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_s5) begin
				infl_q   <= '0;
				stress_q <= '0;
				status_q <= ST_ZERO;
			end else begin
				infl_q   <= infl_s5;
				stress_q <= ssat ? 32'hFFFF_FFFF : ssum[31:0];
				status_q <= (isat_s5 || ssat) ? ST_SAT : ST_OK;
			end
		end
	end

	assign res.valid           = out_valid_q;
	assign res.influence       = infl_q;
	assign res.vertical_stress = stress_q;
	assign res.status          = status_q;

`ifndef SYNTHESIS
	a_ready_follows_out : assert property (@(posedge clk) disable iff (!arst_n)
		pt.ready == (!res.valid || res.ready))
		else $error("input ready does not follow result register");
	a_zero_outputs : assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == ST_ZERO |-> res.influence == 32'd0 &&
		res.vertical_stress == 32'd0)
		else $error("zero distance word carries non-zero results");
	a_status_code : assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.status == ST_OK || res.status == ST_SAT || res.status == ST_ZERO)
		else $error("unknown status code");
	a_stall_holds : assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.influence))
		else $error("stalled result word lost");
`endif

endmodule
`default_nettype wire

>>> sv/plvsf_div_cell.sv
`default_nettype none
module plvsf_div_cell
	import plvsf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire div_t d,
	output div_t      q
);

	div_t        cell_q;
	div_t        nxt;
	logic [64:0] trial;
	logic        ge;

	// one restoring step: bring down the next numerator bit, subtract the divisor if it fits
	always_comb begin
		trial = {d.rem, d.num[QW-1]};
		ge    = trial >= {1'b0, d.side.s};
		nxt   = d;
		nxt.rem = ge ? 64'(trial - {1'b0, d.side.s}) : trial[63:0];
		nxt.quo = {d.quo[QW-2:0], ge};
		nxt.num = {d.num[QW-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= 1'b0;
		end else if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;

endmodule
`default_nettype wire

>>> sv/plvsf_sqrt_cell.sv
`default_nettype none
module plvsf_sqrt_cell
	import plvsf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire sqr_t d,
	output sqr_t      q
);

	sqr_t        cell_q;
	sqr_t        nxt;
	logic [35:0] cur;
	logic [35:0] trial;
	logic        ge;

	// one root bit per step from the next two radicand bits
	always_comb begin
		cur   = {d.rem[33:0], d.rad[63:62]};
		trial = {2'b00, d.root, 2'b01};
		ge    = cur >= trial;
		nxt   = d;
		nxt.rem  = ge ? cur - trial : cur;
		nxt.root = {d.root[RW-2:0], ge};
		nxt.rad  = {d.rad[61:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= 1'b0;
		end else if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none
module tb_top
	import plvsf_pkg::*;
;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [30:0] z;
		logic        known;
		logic [31:0] infl;
		logic [31:0] stress;
		logic [1:0]  st;
	} row_t;

	typedef struct {
		logic [31:0] infl;
		logic [31:0] stress;
		logic [1:0]  st;
	} point_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic [31:0] load_q;

	plvsf_pt_if  pt ();
	plvsf_res_if res ();

	point_load_vertical_stress_factor dut (
		.clk(clk),
		.arst_n(arst_n),
		.pt(pt.sink),
		.res(res.source),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	point_res_t  stress_q[$];
	int          mismatches;
	int          cycles;
	int          src_idle;
	int          snk_idle;
	row_t        rows[$];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [63:0] int_root(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic point_res_t boussinesq(input logic [31:0] x, input logic [31:0] y,
		input logic [30:0] z, input logic [31:0] p);
		point_res_t  o;
		logic [63:0] ax, ay, zz, s, c2, c, c3, q, hi, lo, st;
		logic [127:0] wide;
		logic        sat;
		ax = x[31] ? (64'd1 << 32) - 64'(x) : 64'(x);
		ay = y[31] ? (64'd1 << 32) - 64'(y) : 64'(y);
		zz = 64'(z);
		zz = zz * zz;
		s = ax * ax + ay * ay + zz;
		sat = 1'b0;
		if (s == 0) begin
			o.infl = '0;
			o.stress = '0;
			o.st = ST_ZERO;
			return o;
		end
		if (zz >= s) begin
			c2 = 64'd1 << 32;
			c = c2;
			c3 = c2;
		end else begin
			wide = ({64'd0, zz} << 32) / {64'd0, s};
			c2 = wide[63:0];
			c = int_root(c2 << 32);
			c3 = (c2 * c) >> 32;
		end
		q = ((64'd2050695827 * c3) >> 8) / s;
		if (q > 64'hFFFF_FFFF) begin
			o.infl = '1;
			sat = 1'b1;
		end else begin
			o.infl = q[31:0];
		end
		hi = (q >> 32) * 64'(p);
		if (hi >= (64'd1 << 24)) begin
			o.stress = '1;
			sat = 1'b1;
		end else begin
			lo = {32'd0, q[31:0]} * 64'(p);
			st = (hi << 8) + (lo >> 24);
			if (st > 64'hFFFF_FFFF) begin
				st = 64'hFFFF_FFFF;
				sat = 1'b1;
			end
			o.stress = st[31:0];
		end
		o.st = sat ? ST_SAT : ST_OK;
		return o;
	endfunction

	// check accepted result words against the outstanding results and drive res.ready on the receiving side
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (res.valid && res.ready) begin
			if (stress_q.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected word infl=%h stress=%h st=%0d",
						res.influence, res.vertical_stress, res.status);
			end else begin
				if (res.influence !== stress_q[0].infl
						|| res.vertical_stress !== stress_q[0].stress
						|| res.status !== stress_q[0].st) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("exp %h %h %0d got %h %h %0d", stress_q[0].infl,
							stress_q[0].stress, stress_q[0].st, res.influence,
							res.vertical_stress, res.status);
				end
				void'(stress_q.pop_front());
			end
		end
		res.ready <= ($urandom_range(99) >= snk_idle);
	end

	task automatic write_load(input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		load_q = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		while (stress_q.size() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	// present one point, hold until taken, and queue its result
	task automatic send_point(input row_t r);
		point_res_t e;
		while ($urandom_range(99) < src_idle) begin
			pt.valid <= 1'b0;
			@(posedge clk);
		end
		pt.valid <= 1'b1;
		pt.x_offset <= r.x;
		pt.y_offset <= r.y;
		pt.depth <= r.z;
		e = boussinesq(r.x, r.y, r.z, load_q);
		if (r.known) begin
			e.infl = r.infl;
			e.stress = r.stress;
			e.st = r.st;
		end
		do
			@(posedge clk);
		while (!pt.ready);
		stress_q.push_back(e);
	endtask

	function automatic row_t mk(input logic [31:0] x, input logic [31:0] y,
		input logic [30:0] z);
		row_t r;
		r.x = x;
		r.y = y;
		r.z = z;
		r.known = 1'b0;
		return r;
	endfunction

	function automatic row_t mkk(input logic [31:0] x, input logic [31:0] y,
		input logic [30:0] z, input logic [31:0] i, input logic [31:0] s,
		input logic [1:0] st);
		row_t r;
		r = mk(x, y, z);
		r.known = 1'b1;
		r.infl = i;
		r.stress = s;
		r.st = st;
		return r;
	endfunction

	task automatic random_phase(input int n);
		row_t  r;
		int    k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(9);
			r = mk($urandom, $urandom, 31'($urandom));
			// mostly small, near-load geometry; some full-range noise
			if (k < 5) begin
				r.x = $signed($urandom_range(131071)) - 65536;
				r.y = $signed($urandom_range(131071)) - 65536;
				r.z = 31'($urandom_range(262143));
			end else if (k < 7) begin
				r.x = $signed($urandom_range(4095)) - 2048;
				r.y = $signed($urandom_range(4095)) - 2048;
				r.z = 31'($urandom_range(4095));
			end else if (k == 7) begin
				r.x = 0;
				r.y = 0;
			end
			send_point(r);
		end
		pt.valid <= 1'b0;
	endtask

	initial begin
		cycles = 0;
		mismatches = 0;
		src_idle = 0;
		snk_idle = 0;
		load_q = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 0;
		pt.valid = 1'b0;
		pt.x_offset = 0;
		pt.y_offset = 0;
		pt.depth = 0;
		res.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, load still at reset value
		rows.push_back(mkk(0, 0, 0, 0, 0, ST_ZERO));
		rows.push_back(mkk(32'h0001_0000, 0, 0, 0, 0, ST_OK));
		rows.push_back(mkk(32'h8000_0000, 32'h8000_0000, 0, 0, 0, ST_OK));
		rows.push_back(mk(0, 0, 31'h7FFF_FFFF));
		rows.push_back(mk(0, 0, 31'd1));
		rows.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
		rows.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 31'd65536));
		rows.push_back(mk(32'hFFFF_FFFF, 32'd1, 31'd1));
		rows.push_back(mk(32'h0001_0000, 32'hFFFF_0000, 31'h0001_0000));
		foreach (rows[i])
			send_point(rows[i]);
		pt.valid <= 1'b0;
		drain();

		write_load(32'hFFFF_FFFF);
		rows.delete();
		rows.push_back(mk(0, 0, 31'd1));
		rows.push_back(mk(0, 0, 31'h0001_0000));
		rows.push_back(mk(32'h0000_8000, 32'hFFFF_8000, 31'h0001_0000));
		rows.push_back(mk(0, 0, 31'h7FFF_FFFF));
		rows.push_back(mkk(0, 0, 0, 0, 0, ST_ZERO));
		rows.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 31'h4000_0000));
		foreach (rows[i])
			send_point(rows[i]);
		pt.valid <= 1'b0;
		drain();

		src_idle = 13;
		snk_idle = 47;
		write_load(32'h0001_0000);
		random_phase(550);
		drain();

		src_idle = 47;
		snk_idle = 13;
		write_load($urandom);
		random_phase(550);
		drain();

		src_idle = 0;
		snk_idle = 0;
		write_load(32'h0000_0001);
		random_phase(300);
		drain();
		write_load($urandom_range(32'h00FF_FFFF));
		random_phase(300);
		drain();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

>>> point_load_vertical_stress_factor.f
sv/plvsf_pkg.sv
sv/plvsf_pt_if.sv
sv/plvsf_res_if.sv
sv/plvsf_div_cell.sv
sv/plvsf_sqrt_cell.sv
sv/point_load_vertical_stress_factor.sv
bench/tb_top.sv
